>>> src/escev_pkg.sv
// Shared types and constants for the epoch slot cache evictor.
// Slot record layout, result record, modulo unit handshake, command codes.
// No dependencies.
`default_nettype none

package escev_pkg;

  localparam int EP_W      = 64;
  localparam int CNT_W     = 11;
  localparam int THR_W     = 7;
  localparam int POS_W     = 10;
  localparam int EVC_W     = 9;
  localparam int CMD_W     = 2;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;

  localparam int PCT_SCALE   = 100;
  localparam int EVICT_SHIFT = 2;
  localparam int MUL_W       = CNT_W + THR_W;

  localparam int MOD_RADIX = 4;
  localparam int MOD_STEPS = EP_W / MOD_RADIX;
  localparam int MOD_CNT_W = $clog2(MOD_STEPS);

  localparam logic [CMD_W-1:0] CMD_COMMIT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_EVICT  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 1'd1;

  localparam logic [CFG_W-1:0] SLOT_COUNT_RST = 11'd1024;
  localparam logic [THR_W-1:0] THRESHOLD_RST  = 7'd90;

  typedef struct packed {
    logic            valid;
    logic [EP_W-1:0] guard;
    logic [EP_W-1:0] visible;
  } slot_t;

  typedef struct packed {
    logic [POS_W-1:0] slot_position;
    logic [EP_W-1:0]  old_guard;
    logic             swapped;
    logic [EP_W-1:0]  read_visible;
    logic             read_valid;
    logic [CNT_W-1:0] usage;
    logic [EVC_W-1:0] evicted;
  } res_t;

  typedef struct packed {
    logic             start;
    logic [EP_W-1:0]  dividend;
    logic [CNT_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] rem;
  } mod_rsp_t;

endpackage

`default_nettype wire

>>> src/escev_slot_mem.sv
// Slot store: one write port, one read port, registered read data.
// Uses escev_pkg for the slot record.
`default_nettype none

module escev_slot_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic             clk,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output escev_pkg::slot_t      rd_data,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire escev_pkg::slot_t wr_data
);
  import escev_pkg::*;

  slot_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> src/escev_mod.sv
// Iterative remainder unit: 64-bit dividend by 11-bit divisor, four bits a cycle.
// Uses escev_pkg for widths and the request/response records.
`default_nettype none

module escev_mod (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire escev_pkg::mod_req_t req,
  output escev_pkg::mod_rsp_t     rsp
);
  import escev_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [MOD_CNT_W-1:0] cnt_r;
  logic [EP_W-1:0]      shift_r;
  logic [CNT_W-1:0]     rem_r;
  logic [CNT_W-1:0]     div_r;
  logic [CNT_W-1:0]     rem_step;

  always_comb begin
    logic [CNT_W:0]   t;
    logic [CNT_W-1:0] r;
    r = rem_r;
    for (int k = 0; k < MOD_RADIX; k++) begin
      t = {r, shift_r[EP_W-1-k]};
      if (t >= {1'b0, div_r}) begin
        t = t - {1'b0, div_r};
      end
      r = t[CNT_W-1:0];
    end
    rem_step = r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == MOD_CNT_W'(MOD_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      shift_r <= req.dividend;
      rem_r   <= '0;
      div_r   <= req.divisor;
    end else if (busy_r) begin
      shift_r <= shift_r << MOD_RADIX;
      rem_r   <= rem_step;
    end
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

`default_nettype wire

>>> src/epoch_slot_cache_evictor_core.sv
// Epoch slot cache evictor: sequencer, configuration registers and result register.
// Uses escev_pkg, escev_slot_mem and escev_mod.
//
// Usage:
//   Input channel in_* (valid/ready) carries one command item; the result channel
//   out_* (valid/ready) returns exactly one result item per command.
//   cfg_we/cfg_index/cfg_wdata write slot_count (index 0) and threshold_percent
//   (index 1); write only while the block is idle.
//   After reset the slot store is cleared one entry a cycle, all MAX_SLOTS entries;
//   in_ready stays low until the pass ends.
//   Commit and read: 16 steps of key reduction in the remainder unit (four bits
//   a cycle), a hand-over of the remainder, one slot read and, for a commit, one
//   write-back; with a zero slot count the reduction is skipped.
//   Evict: a counting pass over the store (n active slots); when usage reaches the
//   threshold, a cursor reduction in the remainder unit, an eviction walk over the
//   slots and a second counting pass; with a zero slot count the stored usage is
//   returned without a pass.
//   One item is worked on at a time. The result sits in an output register until
//   taken; a new item is accepted while it waits, and the next result holds in
//   the sequencer until the output register is free.
`default_nettype none

module epoch_slot_cache_evictor_core #(
  parameter int MAX_SLOTS = 1024
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output      logic                               in_ready,
  input  wire logic [escev_pkg::CMD_W-1:0]        in_command,
  input  wire logic [escev_pkg::EP_W-1:0]         in_key_hash,
  input  wire logic [escev_pkg::EP_W-1:0]         in_new_epoch,
  input  wire logic [escev_pkg::EP_W-1:0]         in_expected_epoch,
  input  wire logic                               in_valid_in,
  output      logic                               out_valid,
  input  wire logic                               out_ready,
  output      logic [escev_pkg::POS_W-1:0]        out_slot_position,
  output      logic [escev_pkg::EP_W-1:0]         out_old_guard,
  output      logic                               out_swapped,
  output      logic [escev_pkg::EP_W-1:0]         out_read_visible,
  output      logic                               out_read_valid,
  output      logic [escev_pkg::CNT_W-1:0]        out_usage,
  output      logic [escev_pkg::EVC_W-1:0]        out_evicted,
  input  wire logic                               cfg_we,
  input  wire logic [escev_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [escev_pkg::CFG_W-1:0]        cfg_wdata
);
  import escev_pkg::*;

  localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

  typedef enum logic [10:0] {
    ST_CLEAR = 11'b000_0000_0001,
    ST_IDLE  = 11'b000_0000_0010,
    ST_KMOD  = 11'b000_0000_0100,
    ST_RD    = 11'b000_0000_1000,
    ST_RMW   = 11'b000_0001_0000,
    ST_CNT   = 11'b000_0010_0000,
    ST_CHK   = 11'b000_0100_0000,
    ST_CMOD  = 11'b000_1000_0000,
    ST_WRD   = 11'b001_0000_0000,
    ST_WCHK  = 11'b010_0000_0000,
    ST_OUT   = 11'b100_0000_0000
  } state_t;

  state_t           state_r, state_nxt;
  logic [AW-1:0]    clr_addr_r, clr_addr_nxt;
  logic [CMD_W-1:0] cmd_r, cmd_nxt;
  logic [EP_W-1:0]  new_r, new_nxt;
  logic [EP_W-1:0]  exp_r, exp_nxt;
  logic             vin_r, vin_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [AW-1:0]    slot_r, slot_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             pend_r, pend_nxt;
  logic [CNT_W-1:0] used_r, used_nxt;
  logic             pass2_r, pass2_nxt;
  logic [EVC_W-1:0] target_r, target_nxt;
  logic [EVC_W-1:0] cleared_r, cleared_nxt;
  logic [CNT_W-1:0] steps_r, steps_nxt;
  logic [AW-1:0]    cursor_r, cursor_nxt;
  logic [CNT_W-1:0] usage_count_r, usage_count_nxt;
  res_t             res_r, res_nxt;
  res_t             out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [CFG_W-1:0] slot_count_r, slot_count_nxt;
  logic [THR_W-1:0] thr_r, thr_nxt;

  logic             mem_rd_en;
  logic [AW-1:0]    mem_rd_addr;
  slot_t            mem_rd_data;
  logic             mem_wr_en;
  logic [AW-1:0]    mem_wr_addr;
  slot_t            mem_wr_data;
  mod_req_t         mod_req;
  mod_rsp_t         mod_rsp;

  logic [CNT_W-1:0] active;
  logic             out_free;
  logic             issue;
  logic             guard_match;
  logic [MUL_W-1:0] usage_scaled;
  logic [MUL_W-1:0] thr_scaled;
  logic [CNT_W-1:0] quarter;
  logic [CNT_W-1:0] cur_inc;

  escev_slot_mem #(
    .DEPTH (MAX_SLOTS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  escev_mod u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .rsp   (mod_rsp)
  );

  assign active = (32'(slot_count_r) > MAX_SLOTS) ? CNT_W'(MAX_SLOTS) : slot_count_r;
  assign out_free     = !out_valid_r || out_ready;
  assign issue        = (idx_r != n_r);
  assign guard_match  = (mem_rd_data.guard == exp_r);
  assign usage_scaled = MUL_W'(used_r) * MUL_W'(PCT_SCALE);
  assign thr_scaled   = MUL_W'(thr_r) * MUL_W'(n_r);
  assign quarter      = used_r >> EVICT_SHIFT;
  assign cur_inc      = CNT_W'(cursor_r) + 1'b1;

  always_comb begin
    state_nxt       = state_r;
    clr_addr_nxt    = clr_addr_r;
    cmd_nxt         = cmd_r;
    new_nxt         = new_r;
    exp_nxt         = exp_r;
    vin_nxt         = vin_r;
    n_nxt           = n_r;
    slot_nxt        = slot_r;
    idx_nxt         = idx_r;
    pend_nxt        = pend_r;
    used_nxt        = used_r;
    pass2_nxt       = pass2_r;
    target_nxt      = target_r;
    cleared_nxt     = cleared_r;
    steps_nxt       = steps_r;
    cursor_nxt      = cursor_r;
    usage_count_nxt = usage_count_r;
    res_nxt         = res_r;
    out_nxt         = out_r;
    out_valid_nxt   = out_valid_r;
    slot_count_nxt  = slot_count_r;
    thr_nxt         = thr_r;

    mem_rd_en        = 1'b0;
    mem_rd_addr      = slot_r;
    mem_wr_en        = 1'b0;
    mem_wr_addr      = slot_r;
    mem_wr_data      = '0;
    mod_req.start    = 1'b0;
    mod_req.dividend = in_key_hash;
    mod_req.divisor  = active;

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_SLOT_COUNT: slot_count_nxt = cfg_wdata;
        CFG_THRESHOLD:  thr_nxt = cfg_wdata[THR_W-1:0];
        default:        slot_count_nxt = slot_count_r;
      endcase
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLEAR: begin
        mem_wr_en    = 1'b1;
        mem_wr_addr  = clr_addr_r;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == AW'(MAX_SLOTS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt = in_command;
          new_nxt = in_new_epoch;
          exp_nxt = in_expected_epoch;
          vin_nxt = in_valid_in;
          n_nxt   = active;
          unique case (in_command) inside
            CMD_COMMIT, CMD_READ: begin
              if (active == '0) begin
                slot_nxt  = '0;
                state_nxt = ST_RD;
              end else begin
                mod_req.start = 1'b1;
                state_nxt     = ST_KMOD;
              end
            end
            CMD_EVICT: begin
              if (active == '0) begin
                res_nxt       = '0;
                res_nxt.usage = usage_count_r;
                state_nxt     = ST_OUT;
              end else begin
                idx_nxt   = '0;
                pend_nxt  = 1'b0;
                used_nxt  = '0;
                pass2_nxt = 1'b0;
                state_nxt = ST_CNT;
              end
            end
            default: begin
              res_nxt   = '0;
              state_nxt = ST_OUT;
            end
          endcase
        end
      end
      ST_KMOD: begin
        if (mod_rsp.done) begin
          slot_nxt  = AW'(mod_rsp.rem);
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = slot_r;
        state_nxt   = ST_RMW;
      end
      ST_RMW: begin
        res_nxt               = '0;
        res_nxt.slot_position = POS_W'(slot_r);
        res_nxt.old_guard     = mem_rd_data.guard;
        if (cmd_r == CMD_COMMIT) begin
          mem_wr_en           = 1'b1;
          mem_wr_addr         = slot_r;
          mem_wr_data.valid   = vin_r;
          mem_wr_data.visible = new_r;
          mem_wr_data.guard   = guard_match ? new_r : mem_rd_data.guard;
          res_nxt.swapped     = guard_match;
        end else begin
          res_nxt.read_visible = mem_rd_data.visible;
          res_nxt.read_valid   = mem_rd_data.valid;
        end
        state_nxt = ST_OUT;
      end
      ST_CNT: begin
        if (issue) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = AW'(idx_r);
          idx_nxt     = idx_r + 1'b1;
        end
        pend_nxt = issue;
        if (pend_r && mem_rd_data.valid && (mem_rd_data.guard == mem_rd_data.visible)) begin
          used_nxt = used_r + 1'b1;
        end
        if (!issue && !pend_r) begin
          usage_count_nxt = used_r;
          if (pass2_r) begin
            res_nxt         = '0;
            res_nxt.usage   = used_r;
            res_nxt.evicted = cleared_r;
            state_nxt       = ST_OUT;
          end else begin
            state_nxt = ST_CHK;
          end
        end
      end
      ST_CHK: begin
        if (usage_scaled >= thr_scaled) begin
          target_nxt       = (quarter == '0) ? EVC_W'(1) : EVC_W'(quarter);
          cleared_nxt      = '0;
          steps_nxt        = '0;
          mod_req.start    = 1'b1;
          mod_req.dividend = EP_W'(cursor_r);
          mod_req.divisor  = n_r;
          state_nxt        = ST_CMOD;
        end else begin
          res_nxt       = '0;
          res_nxt.usage = used_r;
          state_nxt     = ST_OUT;
        end
      end
      ST_CMOD: begin
        if (mod_rsp.done) begin
          cursor_nxt = AW'(mod_rsp.rem);
          state_nxt  = ST_WRD;
        end
      end
      ST_WRD: begin
        if ((target_r == '0) || (steps_r == n_r)) begin
          idx_nxt   = '0;
          pend_nxt  = 1'b0;
          used_nxt  = '0;
          pass2_nxt = 1'b1;
          state_nxt = ST_CNT;
        end else begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = cursor_r;
          state_nxt   = ST_WCHK;
        end
      end
      ST_WCHK: begin
        if (mem_rd_data.valid) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = cursor_r;
          target_nxt  = target_r - 1'b1;
          cleared_nxt = cleared_r + 1'b1;
        end
        cursor_nxt = (cur_inc == n_r) ? '0 : AW'(cur_inc);
        steps_nxt  = steps_r + 1'b1;
        state_nxt  = ST_WRD;
      end
      ST_OUT: begin
        if (out_free) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      clr_addr_r    <= '0;
      cursor_r      <= '0;
      usage_count_r <= '0;
      out_valid_r   <= 1'b0;
      slot_count_r  <= SLOT_COUNT_RST;
      thr_r         <= THRESHOLD_RST;
    end else begin
      state_r       <= state_nxt;
      clr_addr_r    <= clr_addr_nxt;
      cursor_r      <= cursor_nxt;
      usage_count_r <= usage_count_nxt;
      out_valid_r   <= out_valid_nxt;
      slot_count_r  <= slot_count_nxt;
      thr_r         <= thr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    new_r     <= new_nxt;
    exp_r     <= exp_nxt;
    vin_r     <= vin_nxt;
    n_r       <= n_nxt;
    slot_r    <= slot_nxt;
    idx_r     <= idx_nxt;
    pend_r    <= pend_nxt;
    used_r    <= used_nxt;
    pass2_r   <= pass2_nxt;
    target_r  <= target_nxt;
    cleared_r <= cleared_nxt;
    steps_r   <= steps_nxt;
    res_r     <= res_nxt;
    out_r     <= out_nxt;
  end

  assign in_ready          = (state_r == ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_slot_position = out_r.slot_position;
  assign out_old_guard     = out_r.old_guard;
  assign out_swapped       = out_r.swapped;
  assign out_read_visible  = out_r.read_visible;
  assign out_read_valid    = out_r.read_valid;
  assign out_usage         = out_r.usage;
  assign out_evicted       = out_r.evicted;

endmodule

`default_nettype wire

>>> tb/sv/epoch_slot_cache_evictor_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for epoch_slot_cache_evictor_core: commits, reads, evictions.
// Holds its own slot table to work out each result; depends on escev_pkg and the core.

module epoch_slot_cache_evictor_core_tb;
  import escev_pkg::*;

  localparam int SLOTS = 1024;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [EP_W-1:0] EP_ONES = '1;
  localparam int RANDOM_ITEMS = 450;

  typedef struct packed {
    logic                 is_cfg;
    logic [CFG_IDX_W-1:0] cidx;
    logic [CFG_W-1:0]     cdata;
    logic [CMD_W-1:0]     cmd;
    logic [EP_W-1:0]      key;
    logic [EP_W-1:0]      nep;
    logic [EP_W-1:0]      eep;
    logic                 vin;
    logic                 typed;
    res_t                 want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [CMD_W-1:0] in_command = '0;
  logic [EP_W-1:0] in_key_hash = '0;
  logic [EP_W-1:0] in_new_epoch = '0;
  logic [EP_W-1:0] in_expected_epoch = '0;
  logic in_valid_in = 1'b0;
  logic out_ready = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  logic in_ready;
  logic out_valid;
  logic [POS_W-1:0] out_slot_position;
  logic [EP_W-1:0] out_old_guard;
  logic out_swapped;
  logic [EP_W-1:0] out_read_visible;
  logic out_read_valid;
  logic [CNT_W-1:0] out_usage;
  logic [EVC_W-1:0] out_evicted;

  epoch_slot_cache_evictor_core #(.MAX_SLOTS(SLOTS)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_command(in_command),
    .in_key_hash(in_key_hash),
    .in_new_epoch(in_new_epoch),
    .in_expected_epoch(in_expected_epoch),
    .in_valid_in(in_valid_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_slot_position(out_slot_position),
    .out_old_guard(out_old_guard),
    .out_swapped(out_swapped),
    .out_read_visible(out_read_visible),
    .out_read_valid(out_read_valid),
    .out_usage(out_usage),
    .out_evicted(out_evicted),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // slot table and registers as the block should hold them
  logic slot_vld [SLOTS];
  logic [EP_W-1:0] slot_grd [SLOTS];
  logic [EP_W-1:0] slot_vis [SLOTS];
  int unsigned cursor;
  int unsigned used_slots;
  logic [CFG_W-1:0] cnt_cfg;
  logic [THR_W-1:0] thr_cfg;

  res_t cache_results_q[$];
  res_t got_res;
  res_t want_res;
  int fault_count = 0;
  int results_seen = 0;
  int evict_hits = 0;
  int items_sent = 0;
  int setting_count = 0;
  int cmd_tally [4];
  int burst_left = 0;
  int stall_left = 0;
  int mode_left = 0;
  bit calm = 1'b0;

  function automatic int unsigned live_slots();
    return (cnt_cfg > SLOTS) ? 32'(SLOTS) : 32'(cnt_cfg);
  endfunction

  function automatic int unsigned slot_of(logic [EP_W-1:0] key);
    logic [EP_W-1:0] n;
    n = EP_W'(live_slots());
    return (n == 0) ? 0 : 32'(key % n);
  endfunction

  function automatic int unsigned recount(int unsigned n);
    int unsigned used;
    used = 0;
    for (int i = 0; i < n; i++) begin
      if (slot_vld[i] && slot_grd[i] == slot_vis[i]) used++;
    end
    used_slots = used;
    return used;
  endfunction

  function automatic res_t apply_cache_cmd(logic [CMD_W-1:0] cmd, logic [EP_W-1:0] key,
                                           logic [EP_W-1:0] nep, logic [EP_W-1:0] eep,
                                           logic vin);
    res_t r;
    int unsigned s, n, used, target, steps, cleared;
    r = '0;
    case (cmd)
      CMD_COMMIT: begin
        s = slot_of(key);
        r.slot_position = POS_W'(s);
        r.old_guard = slot_grd[s];
        slot_vis[s] = nep;
        slot_vld[s] = vin;
        if (slot_grd[s] == eep) begin
          slot_grd[s] = nep;
          r.swapped = 1'b1;
        end
      end
      CMD_READ: begin
        s = slot_of(key);
        r.slot_position = POS_W'(s);
        r.old_guard = slot_grd[s];
        r.read_visible = slot_vis[s];
        r.read_valid = slot_vld[s];
      end
      CMD_EVICT: begin
        n = live_slots();
        cleared = 0;
        if (n != 0) begin
          used = recount(n);
          if (used * PCT_SCALE >= thr_cfg * n) begin
            target = used >> EVICT_SHIFT;
            if (target == 0) target = 1;
            steps = 0;
            cursor = cursor % n;
            while (target > 0 && steps < n) begin
              if (slot_vld[cursor]) begin
                slot_vld[cursor] = 1'b0;
                slot_grd[cursor] = '0;
                slot_vis[cursor] = '0;
                target--;
                cleared++;
              end
              cursor = (cursor + 1) % n;
              steps++;
            end
            used = recount(n);
          end
        end
        r.usage = CNT_W'(used_slots);
        r.evicted = EVC_W'(cleared);
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic res_t res_of(int pos, logic [EP_W-1:0] og, logic sw,
                                  logic [EP_W-1:0] vis, logic vld, int used, int ev);
    res_t r;
    r.slot_position = POS_W'(pos);
    r.old_guard = og;
    r.swapped = sw;
    r.read_visible = vis;
    r.read_valid = vld;
    r.usage = CNT_W'(used);
    r.evicted = EVC_W'(ev);
    return r;
  endfunction

  function automatic stim_row_t op_row(logic [CMD_W-1:0] cmd, logic [EP_W-1:0] key,
                                       logic [EP_W-1:0] nep, logic [EP_W-1:0] eep,
                                       logic vin);
    stim_row_t row;
    row = '0;
    row.cmd = cmd;
    row.key = key;
    row.nep = nep;
    row.eep = eep;
    row.vin = vin;
    return row;
  endfunction

  function automatic stim_row_t fixed_row(logic [CMD_W-1:0] cmd, logic [EP_W-1:0] key,
                                          logic [EP_W-1:0] nep, logic [EP_W-1:0] eep,
                                          logic vin, res_t want);
    stim_row_t row;
    row = op_row(cmd, key, nep, eep, vin);
    row.typed = 1'b1;
    row.want = want;
    return row;
  endfunction

  function automatic stim_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    stim_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.cidx = idx;
    row.cdata = data;
    return row;
  endfunction

  function automatic logic [EP_W-1:0] rand_word();
    logic [EP_W-1:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: w = '0;
      1: w = '1;
      2: w = w & 64'hF;
      default: ;
    endcase
    return w;
  endfunction

  function automatic string res_text(res_t r);
    return $sformatf("pos=%0d guard=%h swap=%0d vis=%h vld=%0d usage=%0d evicted=%0d",
                     r.slot_position, r.old_guard, r.swapped, r.read_visible,
                     r.read_valid, r.usage, r.evicted);
  endfunction

  task automatic push_cmd(input stim_row_t row);
    int gap;
    res_t r;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    in_command <= row.cmd;
    in_key_hash <= row.key;
    in_new_epoch <= row.nep;
    in_expected_epoch <= row.eep;
    in_valid_in <= row.vin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = apply_cache_cmd(row.cmd, row.key, row.nep, row.eep, row.vin);
    cache_results_q.push_back(row.typed ? row.want : r);
    cmd_tally[row.cmd]++;
    items_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (cache_results_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    if (idx == CFG_SLOT_COUNT) cnt_cfg = data;
    else thr_cfg = data[THR_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // receiver stalls: stretches of random length are either calm or hold bursts of random stalls
  always @(negedge clk) begin
    if (mode_left == 0) begin
      calm = ($urandom_range(0, 2) == 0);
      mode_left = $urandom_range(50, 400);
    end else begin
      mode_left--;
    end
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      if (!calm && $urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 12);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got_res.slot_position = out_slot_position;
      got_res.old_guard = out_old_guard;
      got_res.swapped = out_swapped;
      got_res.read_visible = out_read_visible;
      got_res.read_valid = out_read_valid;
      got_res.usage = out_usage;
      got_res.evicted = out_evicted;
      if (got_res.evicted != 0) evict_hits++;
      if (cache_results_q.size() == 0) begin
        fault_count++;
        if (fault_count <= 10) $display("unrequested result: %s", res_text(got_res));
      end else begin
        want_res = cache_results_q.pop_front();
        results_seen++;
        if (got_res.slot_position !== want_res.slot_position ||
            got_res.old_guard !== want_res.old_guard ||
            got_res.swapped !== want_res.swapped ||
            got_res.read_visible !== want_res.read_visible ||
            got_res.read_valid !== want_res.read_valid ||
            got_res.usage !== want_res.usage ||
            got_res.evicted !== want_res.evicted) begin
          fault_count++;
          if (fault_count <= 10) begin
            $display("result %0d differs", results_seen);
            $display("  want %s", res_text(want_res));
            $display("  got  %s", res_text(got_res));
          end
        end
      end
    end
  end

  initial begin
    #60_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    stim_row_t dir_rows[$];
    stim_row_t row;
    int random_left, ph, sel, len, kind;
    logic [CFG_W-1:0] pick_n;
    logic [THR_W-1:0] pick_thr;
    logic [3:0] pad;
    logic [CMD_W-1:0] cmd;
    logic [EP_W-1:0] key, nep, eep;
    logic vin;

    for (int i = 0; i < SLOTS; i++) begin
      slot_vld[i] = 1'b0;
      slot_grd[i] = '0;
      slot_vis[i] = '0;
    end
    for (int i = 0; i < 4; i++) cmd_tally[i] = 0;
    cursor = 0;
    used_slots = 0;
    cnt_cfg = SLOT_COUNT_RST;
    thr_cfg = THRESHOLD_RST;

    // reset defaults: empty table, key extremes, unused code, compare hit and miss
    dir_rows.push_back(fixed_row(CMD_READ, '0, '0, '0, 1'b0, res_of(0, '0, 0, '0, 0, 0, 0)));
    dir_rows.push_back(fixed_row(CMD_READ, EP_ONES, '0, '0, 1'b0,
                                 res_of(SLOTS - 1, '0, 0, '0, 0, 0, 0)));
    dir_rows.push_back(fixed_row(CMD_EVICT, '0, '0, '0, 1'b0, res_of(0, '0, 0, '0, 0, 0, 0)));
    dir_rows.push_back(fixed_row(CMD_UNUSED, EP_ONES, EP_ONES, EP_ONES, 1'b1,
                                 res_of(0, '0, 0, '0, 0, 0, 0)));
    dir_rows.push_back(fixed_row(CMD_COMMIT, 64'd5, EP_ONES, '0, 1'b1,
                                 res_of(5, '0, 1, '0, 0, 0, 0)));
    dir_rows.push_back(fixed_row(CMD_COMMIT, 64'd5, 64'd7, 64'd3, 1'b1,
                                 res_of(5, EP_ONES, 0, '0, 0, 0, 0)));
    dir_rows.push_back(fixed_row(CMD_READ, 64'd5, '0, '0, 1'b0,
                                 res_of(5, EP_ONES, 0, 64'd7, 1, 0, 0)));
    dir_rows.push_back(op_row(CMD_COMMIT, 64'd1029, EP_ONES, EP_ONES, 1'b0));
    // four slots at full threshold: fill, then evict exactly one
    dir_rows.push_back(cfg_row(CFG_SLOT_COUNT, 11'd4));
    dir_rows.push_back(cfg_row(CFG_THRESHOLD, 11'd100));
    dir_rows.push_back(op_row(CMD_COMMIT, 64'd0, 64'd10, '0, 1'b1));
    dir_rows.push_back(op_row(CMD_COMMIT, 64'd1, 64'd11, '0, 1'b1));
    dir_rows.push_back(op_row(CMD_COMMIT, 64'd6, 64'd12, '0, 1'b1));
    dir_rows.push_back(fixed_row(CMD_EVICT, '0, '0, '0, 1'b0, res_of(0, '0, 0, '0, 0, 3, 0)));
    dir_rows.push_back(op_row(CMD_COMMIT, 64'd3, 64'd13, '0, 1'b1));
    dir_rows.push_back(fixed_row(CMD_EVICT, '0, '0, '0, 1'b0, res_of(0, '0, 0, '0, 0, 3, 1)));
    // zero slot count: everything lands on slot zero, evict reports stored usage
    dir_rows.push_back(cfg_row(CFG_SLOT_COUNT, 11'd0));
    dir_rows.push_back(fixed_row(CMD_COMMIT, EP_ONES, 64'd9, '0, 1'b1,
                                 res_of(0, '0, 1, '0, 0, 0, 0)));
    dir_rows.push_back(fixed_row(CMD_EVICT, '0, '0, '0, 1'b0, res_of(0, '0, 0, '0, 0, 3, 0)));
    // slot count above the table size, zero threshold with junk upper bits
    dir_rows.push_back(cfg_row(CFG_SLOT_COUNT, 11'h7FF));
    dir_rows.push_back(cfg_row(CFG_THRESHOLD, 11'h780));
    dir_rows.push_back(op_row(CMD_EVICT, EP_ONES, EP_ONES, EP_ONES, 1'b1));
    dir_rows.push_back(op_row(CMD_READ, 64'd1, '0, '0, 1'b0));
    dir_rows.push_back(cfg_row(CFG_THRESHOLD, 11'h07F));
    dir_rows.push_back(op_row(CMD_EVICT, '0, '0, '0, 1'b0));
    // single slot with nothing valid: full sweep, cursor wraps into range
    dir_rows.push_back(cfg_row(CFG_SLOT_COUNT, 11'd1));
    dir_rows.push_back(cfg_row(CFG_THRESHOLD, 11'd0));
    dir_rows.push_back(op_row(CMD_COMMIT, 64'h8000_0000_0000_0000, 64'd5, 64'd1, 1'b0));
    dir_rows.push_back(op_row(CMD_EVICT, '0, '0, '0, 1'b0));

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        wait_idle();
        cfg_write(dir_rows[i].cidx, dir_rows[i].cdata);
        setting_count++;
      end else begin
        push_cmd(dir_rows[i]);
      end
    end

    random_left = RANDOM_ITEMS;
    ph = 0;
    while (random_left > 0) begin
      wait_idle();
      sel = (ph < 5) ? ph : $urandom_range(0, 9);
      case (sel)
        0: pick_n = '0;
        1: pick_n = CFG_W'(SLOTS);
        2: pick_n = CFG_W'($urandom_range(SLOTS + 1, 2047));
        3: pick_n = CFG_W'(1);
        default: pick_n = CFG_W'($urandom_range(2, 24));
      endcase
      sel = (ph < 5) ? ph : $urandom_range(0, 9);
      case (sel)
        0: pick_thr = '0;
        1: pick_thr = 7'd100;
        2: pick_thr = THR_W'($urandom_range(101, 127));
        default: pick_thr = THR_W'($urandom_range(20, 95));
      endcase
      pad = 4'($urandom_range(0, 15));
      cfg_write(CFG_SLOT_COUNT, pick_n);
      cfg_write(CFG_THRESHOLD, {pad, pick_thr});
      setting_count++;
      len = $urandom_range(30, 70);
      if (len > random_left) len = random_left;
      for (int k = 0; k < len; k++) begin
        kind = $urandom_range(0, 99);
        key = rand_word();
        nep = rand_word();
        eep = rand_word();
        vin = 1'($urandom_range(0, 1));
        if (kind < 55) begin
          cmd = CMD_COMMIT;
          // mostly compare against the live guard so slots stay consistent
          if ($urandom_range(0, 4) != 0) eep = slot_grd[slot_of(key)];
          vin = ($urandom_range(0, 9) != 0);
        end else if (kind < 75) begin
          cmd = CMD_READ;
        end else if (kind < 93) begin
          cmd = CMD_EVICT;
        end else begin
          cmd = CMD_UNUSED;
        end
        row = op_row(cmd, key, nep, eep, vin);
        push_cmd(row);
      end
      random_left -= len;
      ph++;
    end

    wait_idle();
    repeat (3 * SLOTS + 64) @(negedge clk);

    $display("covered %0d items: %0d commit, %0d read, %0d evict, %0d unused, %0d settings",
             items_sent, cmd_tally[CMD_COMMIT], cmd_tally[CMD_READ], cmd_tally[CMD_EVICT],
             cmd_tally[CMD_UNUSED], setting_count);
    $display("%0d results checked, %0d evictions cleared slots, %0d faults",
             results_seen, evict_hits, fault_count);
    if (fault_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> sim.f
src/escev_pkg.sv
src/escev_slot_mem.sv
src/escev_mod.sv
src/epoch_slot_cache_evictor_core.sv
tb/sv/epoch_slot_cache_evictor_core_tb.sv
